// ===== rtl/sbre_pkg.sv =====
package sbre_pkg;

  // Default request queue depth and fixed parameter byte count
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned ParamBytes    = 4;

  // Shortest legal length field
  localparam logic [2:0] MinLen = 3'd3;

  // Number of reply bytes kept
  localparam logic [3:0] ReplyMax = 4'd10;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_ENQ    = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_RX     = 2'd2,
    KIND_RX_ERR = 2'd3
  } sbre_kind_e;

  // Result item kinds
  typedef enum logic [1:0] {
    OUT_TX    = 2'd0,
    OUT_ENQ   = 2'd1,
    OUT_REPLY = 2'd2
  } sbre_out_kind_e;

  // Reply status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CMD  = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_BAD_CSUM = 3'd3,
    ST_BAD_ID   = 3'd4,
    ST_RX_ERR   = 3'd5
  } sbre_status_e;

  typedef logic [ParamBytes-1:0][7:0] sbre_params_t;

  // Input request payload
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] servo_id;
    logic [7:0] command;
    logic [2:0] command_len;
    logic [7:0] param_0;
    logic [7:0] param_1;
    logic [7:0] param_2;
    logic [7:0] param_3;
    logic       wants_reply;
    logic [2:0] expected_reply_len;
    logic [7:0] rx_byte;
  } sbre_req_t;

  // Result payload
  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       accepted;
    logic [2:0] status;
    logic [7:0] reply_command;
    logic [7:0] reply_len;
    logic [7:0] reply_p0;
    logic [7:0] reply_p1;
    logic [7:0] reply_p2;
    logic [7:0] reply_p3;
  } sbre_res_t;

  // One queued bus request
  typedef struct packed {
    logic [7:0]   id;
    logic [7:0]   cmd;
    logic [2:0]   len;
    sbre_params_t params;
    logic         wants;
    logic [2:0]   exp_len;
  } sbre_entry_t;

  // What was sent, kept for reply checking
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] cmd;
    logic [2:0] exp_len;
  } sbre_summary_t;

  // Reply checker verdict
  typedef struct packed {
    logic [2:0]   status;
    logic [7:0]   cmd;
    logic [7:0]   len;
    sbre_params_t params;
  } sbre_reply_t;

  // Raise short length fields to the minimum
  function automatic logic [2:0] clamp_len(input logic [2:0] len);
    return (len < MinLen) ? MinLen : len;
  endfunction

  // Frame checksum: low byte of the inverted sum over id, length, command and the params that the length covers
  function automatic logic [7:0] frame_csum(input logic [7:0] id, input logic [7:0] len,
                                            input logic [7:0] cmd, input sbre_params_t p);
    logic [7:0] sum;
    sum = id + len + cmd;
    for (int i = 0; i < ParamBytes; i++) begin
      if (9'(i + 3) < {1'b0, len}) begin
        sum = sum + p[i];
      end
    end
    return ~sum;
  endfunction

endpackage

// ===== rtl/sbre_req_if.sv =====
interface sbre_req_if import sbre_pkg::*; ();
  logic      valid;
  logic      ready;
  sbre_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sbre_res_if.sv =====
interface sbre_res_if import sbre_pkg::*; ();
  logic      valid;
  logic      ready;
  sbre_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sbre_queue.sv =====
module sbre_queue import sbre_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  sbre_entry_t wr_data_i,
  input  logic        rd_en_i,
  output sbre_entry_t rd_data_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  sbre_entry_t     mem [DEPTH];
  sbre_entry_t     rd_data_q;
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Advance pointers and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (wr_en_i) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      cnt_d  = cnt_q + 1'b1;
    end else if (rd_en_i) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      cnt_d  = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Write the request store
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wptr_q] <= wr_data_i;
    end
  end

  // Registered read; hold the data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rptr_q];
    end
  end

  assign rd_data_o = rd_data_q;
  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);

endmodule

// ===== rtl/sbre_reply.sv =====
module sbre_reply import sbre_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          clr_i,
  input  logic          wr_i,
  input  logic [7:0]    byte_i,
  input  sbre_summary_t summary_i,
  output logic          last_o,
  output sbre_reply_t   reply_o
);

  logic [7:0] rb_q [10];
  logic [3:0] cnt_q;
  logic [3:0] exp_total;
  logic [7:0] rlen;
  logic [7:0] rcmd;
  logic [7:0] csum;
  logic [3:0] csum_idx;
  sbre_params_t rparams;

  // Collect reply bytes in arrival order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < 10; i++) begin
        rb_q[i] <= '0;
      end
    end else if (clr_i) begin
      cnt_q <= '0;
      for (int i = 0; i < 10; i++) begin
        rb_q[i] <= '0;
      end
    end else if (wr_i) begin
      if (cnt_q < ReplyMax) begin
        rb_q[cnt_q] <= byte_i;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Flag the byte that completes the expected reply
  assign exp_total = {1'b0, summary_i.exp_len} + 4'd3;
  assign last_o    = ((cnt_q + 4'd1) >= exp_total);

  assign rlen     = rb_q[3];
  assign rcmd     = rb_q[4];
  assign rparams  = {rb_q[8], rb_q[7], rb_q[6], rb_q[5]};
  assign csum     = frame_csum(summary_i.id, rlen, rcmd, rparams);
  assign csum_idx = rlen[3:0] + 4'd2;

  // Check command, length, checksum and responder in that order
  always_comb begin
    reply_o     = '0;
    reply_o.cmd = rcmd;
    reply_o.len = rlen;
    for (int i = 0; i < ParamBytes; i++) begin
      reply_o.params[i] = (9'(i + 3) < {1'b0, rlen}) ? rparams[i] : 8'd0;
    end
    if (rcmd != summary_i.cmd) begin
      reply_o.status = ST_BAD_CMD;
    end else if (rlen != {5'd0, summary_i.exp_len}) begin
      reply_o.status = ST_BAD_LEN;
    end else if (csum_idx > 4'd9 || csum != rb_q[csum_idx]) begin
      reply_o.status = ST_BAD_CSUM;
    end else if (rb_q[2] != summary_i.id) begin
      reply_o.status = ST_BAD_ID;
    end else begin
      reply_o.status = ST_OK;
    end
  end

endmodule

// ===== rtl/servo_bus_request_reply_engine_unit.sv =====
// Servo bus request/reply engine. Enqueue requests (id, command, length,
// four parameter bytes, reply wanted, expected reply length) into a queue of
// QUEUE_DEPTH entries held in a synchronous memory; a full queue refuses the
// request. A tick with the bus idle and the queue not empty sends the oldest
// request as header, header, id, length, command, parameters, checksum, one
// frame byte per result. When a reply is wanted, received bytes are collected
// until the expected length is reached, then one reply-finished result reports
// the status and up to four reply parameters; a receive error ends the wait.
// An enqueue answers from a separate state, and a byte that completes the reply
// passes through a finish state. The frame sequencer moves one byte per cycle
// into a single output register, so every result cycle also waits on
// res_o.ready. No clearing pass after reset.
module servo_bus_request_reply_engine_unit import sbre_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  sbre_req_if.sink   req_i,
  sbre_res_if.source res_o,
  input logic        cfg_we_i,
  input logic [7:0]  cfg_wdata_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_ANS,
    S_TX,
    S_FIN,
    S_ERR
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    header_q, header_d;
  logic          acc_q, acc_d;
  logic [3:0]    idx_q, idx_d;
  logic          awaiting_q, awaiting_d;
  sbre_summary_t summary_q, summary_d;
  sbre_res_t     res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic          accept;
  logic          out_free;
  logic          q_wr, q_rd, q_full, q_empty;
  sbre_entry_t   q_wdata, entry;
  logic          rp_clr, rp_wr, rp_last;
  sbre_reply_t   reply;
  logic [3:0]    last_idx;
  logic [1:0]    pidx;
  logic [7:0]    tx_csum;
  logic [7:0]    tx_byte;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;

  // Pack the incoming request for the store
  always_comb begin
    q_wdata.id        = req_i.payload.servo_id;
    q_wdata.cmd       = req_i.payload.command;
    q_wdata.len       = clamp_len(req_i.payload.command_len);
    q_wdata.params    = {req_i.payload.param_3, req_i.payload.param_2,
                         req_i.payload.param_1, req_i.payload.param_0};
    q_wdata.wants     = req_i.payload.wants_reply;
    q_wdata.exp_len   = clamp_len(req_i.payload.expected_reply_len);
  end

  sbre_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (q_wr),
    .wr_data_i (q_wdata),
    .rd_en_i   (q_rd),
    .rd_data_o (entry),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  sbre_reply u_reply (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clr_i     (rp_clr),
    .wr_i      (rp_wr),
    .byte_i    (req_i.payload.rx_byte),
    .summary_i (summary_q),
    .last_o    (rp_last),
    .reply_o   (reply)
  );

  // Select the frame byte at the current position
  assign last_idx = {1'b0, entry.len} + 4'd2;
  assign pidx     = 2'(idx_q - 4'd5);
  assign tx_csum  = frame_csum(entry.id, {5'd0, entry.len}, entry.cmd, entry.params);

  always_comb begin
    case (idx_q)
      4'd0, 4'd1: tx_byte = header_q;
      4'd2:       tx_byte = entry.id;
      4'd3:       tx_byte = {5'd0, entry.len};
      4'd4:       tx_byte = entry.cmd;
      default:    tx_byte = (idx_q == last_idx) ? tx_csum : entry.params[pidx];
    endcase
  end

  // Sequence requests and load results into the output register
  always_comb begin
    state_d     = state_q;
    header_d    = cfg_we_i ? cfg_wdata_i : header_q;
    acc_d       = acc_q;
    idx_d       = idx_q;
    awaiting_d  = awaiting_q;
    summary_d   = summary_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_o.ready;
    q_wr        = 1'b0;
    q_rd        = 1'b0;
    rp_clr      = 1'b0;
    rp_wr       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.payload.kind)
            KIND_ENQ: begin
              q_wr    = !q_full;
              acc_d   = !q_full;
              state_d = S_ENQ_ANS;
            end
            KIND_TICK: begin
              if (!awaiting_q && !q_empty) begin
                q_rd    = 1'b1;
                idx_d   = '0;
                state_d = S_TX;
              end
            end
            KIND_RX: begin
              if (awaiting_q) begin
                rp_wr = 1'b1;
                if (rp_last) begin
                  state_d = S_FIN;
                end
              end
            end
            KIND_RX_ERR: begin
              if (awaiting_q) begin
                awaiting_d = 1'b0;
                state_d    = S_ERR;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ENQ_ANS: begin
        if (out_free) begin
          res_d          = '0;
          res_d.out_kind = OUT_ENQ;
          res_d.accepted = acc_q;
          res_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_TX: begin
        if (out_free) begin
          res_d           = '0;
          res_d.out_kind  = OUT_TX;
          res_d.tx_byte   = tx_byte;
          res_d.last_byte = (idx_q == last_idx);
          res_valid_d     = 1'b1;
          idx_d           = idx_q + 4'd1;
          if (idx_q == last_idx) begin
            awaiting_d        = entry.wants;
            summary_d.id      = entry.id;
            summary_d.cmd     = entry.cmd;
            summary_d.exp_len = entry.exp_len;
            rp_clr            = entry.wants;
            state_d           = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          res_d               = '0;
          res_d.out_kind      = OUT_REPLY;
          res_d.status        = reply.status;
          res_d.reply_command = reply.cmd;
          res_d.reply_len     = reply.len;
          res_d.reply_p0      = reply.params[0];
          res_d.reply_p1      = reply.params[1];
          res_d.reply_p2      = reply.params[2];
          res_d.reply_p3      = reply.params[3];
          res_valid_d         = 1'b1;
          awaiting_d          = 1'b0;
          state_d             = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          res_d          = '0;
          res_d.out_kind = OUT_REPLY;
          res_d.status   = ST_RX_ERR;
          res_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      header_q    <= 8'd85;
      acc_q       <= 1'b0;
      idx_q       <= '0;
      awaiting_q  <= 1'b0;
      summary_q   <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      header_q    <= header_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      awaiting_q  <= awaiting_d;
      summary_q   <= summary_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

endmodule

// ===== tb/sv/servo_bus_request_reply_engine_unit_test.sv =====
`timescale 1ns / 100ps

import sbre_pkg::*;

// Track queued bus requests, sent frames and collected reply bytes; hold the results due
class bus_frame_tracker;
  sbre_res_t   due_q[$];
  sbre_entry_t pending_q[$];
  int unsigned mismatches;
  logic [7:0]  header;
  bit          awaiting;
  logic [7:0]  sent_id;
  logic [7:0]  sent_cmd;
  logic [2:0]  sent_exp;
  logic [7:0]  reply_buf[ReplyMax];
  int unsigned reply_cnt;

  function new();
    header     = 8'h55;
    mismatches = 0;
    awaiting   = 1'b0;
    sent_id    = '0;
    sent_cmd   = '0;
    sent_exp   = '0;
    reply_cnt  = 0;
    foreach (reply_buf[i]) reply_buf[i] = '0;
  endfunction

  // Raise short length fields to the minimum
  function logic [2:0] raise_len(logic [2:0] v);
    return (v < MinLen) ? MinLen : v;
  endfunction

  // Queue one frame byte per result; arm the reply wait if one is wanted
  function void emit_frame(sbre_entry_t e);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    sbre_res_t  res;
    bytes_q.push_back(header);
    bytes_q.push_back(header);
    bytes_q.push_back(e.id);
    bytes_q.push_back({5'b0, e.len});
    bytes_q.push_back(e.cmd);
    sum = e.id + {5'b0, e.len} + e.cmd;
    for (int i = 0; i < ParamBytes; i++) begin
      if (i + 3 < e.len) begin
        bytes_q.push_back(e.params[i]);
        sum = sum + e.params[i];
      end
    end
    bytes_q.push_back(~sum);
    foreach (bytes_q[i]) begin
      res           = '0;
      res.out_kind  = OUT_TX;
      res.tx_byte   = bytes_q[i];
      res.last_byte = (i == bytes_q.size() - 1);
      due_q.push_back(res);
    end
    if (e.wants) begin
      awaiting  = 1'b1;
      sent_id   = e.id;
      sent_cmd  = e.cmd;
      sent_exp  = e.exp_len;
      reply_cnt = 0;
      foreach (reply_buf[i]) reply_buf[i] = '0;
    end
  endfunction

  // Judge the collected reply: command, length, checksum with the sent id, responder
  function void finish_reply();
    logic [7:0] rlen;
    logic [7:0] rcmd;
    logic [7:0] sum;
    int         idx;
    sbre_res_t  res;
    rlen         = reply_buf[3];
    rcmd         = reply_buf[4];
    res          = '0;
    res.out_kind = OUT_REPLY;
    res.status   = ST_OK;
    if (rcmd != sent_cmd) begin
      res.status = ST_BAD_CMD;
    end else if (rlen != {5'b0, sent_exp}) begin
      res.status = ST_BAD_LEN;
    end else begin
      sum = sent_id + rlen + rcmd;
      for (int i = 0; i < ParamBytes; i++) begin
        if (i + 3 < rlen) sum = sum + reply_buf[5 + i];
      end
      idx = (int'(rlen) + 2) % ReplyMax;
      if (~sum != reply_buf[idx]) begin
        res.status = ST_BAD_CSUM;
      end else if (reply_buf[2] != sent_id) begin
        res.status = ST_BAD_ID;
      end
    end
    res.reply_command = rcmd;
    res.reply_len     = rlen;
    res.reply_p0      = (3 < rlen) ? reply_buf[5] : 8'h00;
    res.reply_p1      = (4 < rlen) ? reply_buf[6] : 8'h00;
    res.reply_p2      = (5 < rlen) ? reply_buf[7] : 8'h00;
    res.reply_p3      = (6 < rlen) ? reply_buf[8] : 8'h00;
    due_q.push_back(res);
    awaiting  = 1'b0;
    reply_cnt = 0;
  endfunction

  // Advance the model by one accepted request; return 1 unless the block ignores it
  function bit note_request(sbre_req_t r);
    sbre_res_t   res;
    sbre_entry_t e;
    case (r.kind)
      KIND_ENQ: begin
        res          = '0;
        res.out_kind = OUT_ENQ;
        if (pending_q.size() < QueueDepthDef) begin
          e.id        = r.servo_id;
          e.cmd       = r.command;
          e.len       = raise_len(r.command_len);
          e.params[0] = r.param_0;
          e.params[1] = r.param_1;
          e.params[2] = r.param_2;
          e.params[3] = r.param_3;
          e.wants     = r.wants_reply;
          e.exp_len   = raise_len(r.expected_reply_len);
          pending_q.push_back(e);
          res.accepted = 1'b1;
        end
        due_q.push_back(res);
        return 1'b1;
      end
      KIND_TICK: begin
        if (awaiting || pending_q.size() == 0) return 1'b0;
        emit_frame(pending_q.pop_front());
        return 1'b1;
      end
      KIND_RX_ERR: begin
        if (!awaiting) return 1'b0;
        res          = '0;
        res.out_kind = OUT_REPLY;
        res.status   = ST_RX_ERR;
        due_q.push_back(res);
        awaiting  = 1'b0;
        reply_cnt = 0;
        return 1'b1;
      end
      default: begin
        if (!awaiting) return 1'b0;
        if (reply_cnt < ReplyMax) reply_buf[reply_cnt] = r.rx_byte;
        reply_cnt++;
        if (reply_cnt >= sent_exp + 3) finish_reply();
        return 1'b1;
      end
    endcase
  endfunction

  function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one result with the oldest one due
  function void check_result(sbre_res_t got);
    sbre_res_t want;
    if (due_q.size() == 0) begin
      $display("%0t: result with nothing due: expected none, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = due_q.pop_front();
    cmp_field("out_kind", want.out_kind, got.out_kind);
    cmp_field("tx_byte", want.tx_byte, got.tx_byte);
    cmp_field("last_byte", want.last_byte, got.last_byte);
    cmp_field("accepted", want.accepted, got.accepted);
    cmp_field("status", want.status, got.status);
    cmp_field("reply_command", want.reply_command, got.reply_command);
    cmp_field("reply_len", want.reply_len, got.reply_len);
    cmp_field("reply_p0", want.reply_p0, got.reply_p0);
    cmp_field("reply_p1", want.reply_p1, got.reply_p1);
    cmp_field("reply_p2", want.reply_p2, got.reply_p2);
    cmp_field("reply_p3", want.reply_p3, got.reply_p3);
  endfunction
endclass

module servo_bus_request_reply_engine_unit_test;
  localparam int unsigned IdleLimit     = 2000;
  localparam int unsigned HoldCycles    = 16;
  localparam int unsigned TailCycles    = 40;
  localparam int unsigned ItemsPerPhase = 82;

  typedef enum int {
    REPLY_CLEAN    = 0,
    REPLY_BAD_CMD  = 1,
    REPLY_BAD_LEN  = 2,
    REPLY_BAD_CSUM = 3,
    REPLY_BAD_ID   = 4,
    REPLY_ABORT    = 5
  } reply_flaw_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we;
  logic [7:0]       cfg_wdata;
  int unsigned      requests_done = 0;
  int unsigned      idle_cycles = 0;
  bit               send_quiet = 1'b0;
  bit               recv_quiet = 1'b0;
  bus_frame_tracker sb;

  sbre_req_if req_if ();
  sbre_res_if res_if ();

  servo_bus_request_reply_engine_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Drop the run when nothing moves on either channel for too long
  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic sbre_req_t random_item(sbre_kind_e k);
    sbre_req_t r;
    r.kind               = k;
    r.servo_id           = 8'($urandom);
    r.command            = 8'($urandom);
    r.command_len        = 3'($urandom);
    r.param_0            = 8'($urandom);
    r.param_1            = 8'($urandom);
    r.param_2            = 8'($urandom);
    r.param_3            = 8'($urandom);
    r.wants_reply        = 1'($urandom);
    r.expected_reply_len = 3'($urandom);
    r.rx_byte            = 8'($urandom);
    return r;
  endfunction

  // Drive one request after a random gap and feed it to the model at the handshake
  task automatic send_request(sbre_req_t r);
    int unsigned gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    void'(sb.note_request(r));
    requests_done++;
  endtask

  // Hold off new requests until every due result has come, then let the block settle
  task automatic hold_until_drained();
    req_if.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (HoldCycles) @(posedge clk_i);
  endtask

  task automatic write_header(logic [7:0] value);
    hold_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.header = value;
  endtask

  // Answer the outstanding frame with a reply, optionally flawed or cut short
  task automatic send_reply(reply_flaw_e flaw);
    logic [7:0]  frame[10];
    logic [7:0]  sum;
    int unsigned total;
    int unsigned cut;
    sbre_req_t   r;
    total = sb.sent_exp + 3;
    foreach (frame[i]) frame[i] = 8'($urandom);
    frame[2] = sb.sent_id;
    frame[3] = {5'b0, sb.sent_exp};
    frame[4] = sb.sent_cmd;
    sum = frame[2] + frame[3] + frame[4];
    for (int i = 5; i < total - 1; i++) sum = sum + frame[i];
    frame[total - 1] = ~sum;
    case (flaw)
      REPLY_BAD_CMD:  frame[4] = frame[4] ^ 8'($urandom_range(1, 255));
      REPLY_BAD_LEN: begin
        do frame[3] = 8'($urandom); while (frame[3] == {5'b0, sb.sent_exp});
      end
      REPLY_BAD_CSUM: frame[total - 1] = frame[total - 1] ^ 8'($urandom_range(1, 255));
      REPLY_BAD_ID:   frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    cut = (flaw == REPLY_ABORT) ? $urandom_range(0, total - 1) : total;
    for (int i = 0; i < cut; i++) begin
      // Slip an enqueue in now and then while the reply is still open
      if ($urandom_range(0, 9) == 0) send_request(random_item(KIND_ENQ));
      r         = random_item(KIND_RX);
      r.rx_byte = frame[i];
      send_request(r);
    end
    if (flaw == REPLY_ABORT) send_request(random_item(KIND_RX_ERR));
  endtask

  // Pick mostly replies, half of them clean, while one is awaited, else enqueue, tick or a stray receive
  task automatic random_step(int unsigned enq_weight);
    int unsigned pick;
    int unsigned f;
    pick = $urandom_range(0, 9);
    if (sb.awaiting) begin
      if (pick < 7) begin
        f = $urandom_range(0, 9);
        send_reply((f < 5) ? REPLY_CLEAN : reply_flaw_e'(f - 4));
      end else if (pick == 7) begin
        send_request(random_item(KIND_TICK));
      end else if (pick == 8) begin
        send_request(random_item(KIND_ENQ));
      end else begin
        send_request(random_item(KIND_RX));
      end
    end else begin
      if (pick < enq_weight) begin
        send_request(random_item(KIND_ENQ));
      end else if (pick < 9) begin
        send_request(random_item(KIND_TICK));
      end else begin
        send_request(random_item($urandom_range(0, 1) ? KIND_RX : KIND_RX_ERR));
      end
    end
  endtask

  task automatic run_phase(int unsigned stop_at);
    int unsigned enq_weight;
    enq_weight = $urandom_range(3, 7);
    while (requests_done < stop_at) begin
      if ($urandom_range(0, 29) == 0) send_quiet = ~send_quiet;
      random_step(enq_weight);
    end
  endtask

  // Accept results after random stalls, with stretches of none
  initial begin
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      sb.check_result(res_if.payload);
      taken++;
      if (taken % 40 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin
    sbre_req_t item;
    sb = new();
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Poke the idle bus: tick on an empty queue, stray byte, stray receive error
    send_request(random_item(KIND_TICK));
    item         = random_item(KIND_RX);
    item.rx_byte = 8'hFF;
    send_request(item);
    send_request(random_item(KIND_RX_ERR));

    // Fill the queue: all-zero request with short lengths, all-ones request, then overflow
    item             = '0;
    item.kind        = KIND_ENQ;
    item.wants_reply = 1'b1;
    send_request(item);
    item             = '1;
    item.kind        = KIND_ENQ;
    item.wants_reply = 1'b0;
    send_request(item);
    repeat (7) send_request(random_item(KIND_ENQ));

    // Send the first frame, tick while busy, close with a clean reply, then a no-reply frame
    send_request(random_item(KIND_TICK));
    send_request(random_item(KIND_TICK));
    send_reply(REPLY_CLEAN);
    send_request(random_item(KIND_TICK));

    run_phase(requests_done + ItemsPerPhase);
    write_header(8'h00);
    run_phase(requests_done + ItemsPerPhase);
    write_header(8'hFF);
    run_phase(requests_done + ItemsPerPhase);
    write_header(8'($urandom));
    run_phase(requests_done + ItemsPerPhase);

    hold_until_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/sbre_pkg.sv
rtl/sbre_req_if.sv
rtl/sbre_res_if.sv
rtl/sbre_queue.sv
rtl/sbre_reply.sv
rtl/servo_bus_request_reply_engine_unit.sv
tb/sv/servo_bus_request_reply_engine_unit_test.sv
